@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is muted while reset is high.
`define JBP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define JBP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/jbp_pkg.sv @@
// ----------------------------------------------------------------------------
// JPEG bit packer package
// Payload structs for both channels and the front-to-back queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

package jbp_pkg;

  localparam int unsigned NUM_BITS_W = 6;
  localparam int unsigned CODE_W     = 32;
  localparam int unsigned TOTAL_W    = 21;

  // Operation codes of an input item.
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  localparam logic [7:0] MARKER_BYTE = 8'hFF;
  localparam logic [7:0] STUFF_BYTE  = 8'h00;

  typedef struct packed {
    logic                  op;
    logic [NUM_BITS_W-1:0] num_bits;
    logic [CODE_W-1:0]     code_value;
  } code_item_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               last;
    logic [TOTAL_W-1:0] total_bytes;
  } byte_item_t;

  // Classified work handed from the front end to the packing engine.
  typedef struct packed {
    logic                  flush;
    logic [NUM_BITS_W-1:0] num_bits;
    logic [CODE_W-1:0]     code;
  } work_entry_t;

endpackage

`default_nettype wire

@@ hdl/jpeg_bit_packer_byte_stuffing_core.sv @@
// ----------------------------------------------------------------------------
// JPEG bit packer with byte stuffing
// Packs variable-length codes MSB first into scan bytes, follows every 0xFF
// byte with a stuffed 0x00, and pads the last partial byte with ones on flush.
// ----------------------------------------------------------------------------
//
//   Channel  Signals                              Payload
//   code     code_valid / code_ready / code_data  op, num_bits, code_value
//   byte     byte_valid / byte_ready / byte_data  out_byte, last, total_bytes
//
// An append or flush item occupies the packing engine while it loads the
// accumulator and then until its last byte (stuffed zeros included) has
// entered the engine's single byte output register; a short code that
// completes no byte only loads the accumulator.
// A two-entry queue in front of the engine keeps accepting items while the
// engine works or the output is stalled; code_ready drops only when it fills.
// Reset is synchronous and empties the queue, the accumulator and the count.
//
`default_nettype none

module jpeg_bit_packer_byte_stuffing_core #(
  parameter int unsigned MAX_CODE_BITS = 32,
  parameter int unsigned COUNT_BITS    = 21
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 code_valid,
  output logic                      code_ready,
  input  wire jbp_pkg::code_item_t  code_data,
  output logic                      byte_valid,
  input  wire logic                 byte_ready,
  output jbp_pkg::byte_item_t       byte_data
);

  // Work handed from the front end to the engine.
  logic                 work_valid;
  logic                 work_ready;
  jbp_pkg::work_entry_t work_data;

  // The front end saturates the length, clears code bits above it and drops
  // appends of zero bits, since those never change the stream.
  jbp_front #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .code_valid (code_valid),
    .code_ready (code_ready),
    .code_data  (code_data),
    .work_valid (work_valid),
    .work_ready (work_ready),
    .work_data  (work_data)
  );

  // The engine owns the accumulator and the running byte count. A flush with
  // no pending bits is absorbed there without producing a byte.
  jbp_back #(
    .MAX_CODE_BITS (MAX_CODE_BITS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .work_valid (work_valid),
    .work_ready (work_ready),
    .work_data  (work_data),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data)
  );

endmodule

`default_nettype wire

@@ hdl/jbp_front.sv @@
// ----------------------------------------------------------------------------
// JPEG bit packer front end
// Accepts items, saturates and masks codes, drops empty appends, and queues
// the remaining work in a two-entry queue for the packing engine.
// ----------------------------------------------------------------------------
`default_nettype none

module jbp_front #(
  parameter int unsigned MAX_CODE_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 code_valid,
  output logic                      code_ready,
  input  wire jbp_pkg::code_item_t  code_data,
  output logic                      work_valid,
  input  wire logic                 work_ready,
  output jbp_pkg::work_entry_t      work_data
);

  localparam logic [jbp_pkg::NUM_BITS_W-1:0] MAX_N = jbp_pkg::NUM_BITS_W'(MAX_CODE_BITS);

  jbp_pkg::work_entry_t queue [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           fill;

  logic [jbp_pkg::NUM_BITS_W-1:0] n_sat;
  logic [jbp_pkg::CODE_W-1:0]     code_mask;
  logic                           is_flush;
  logic                           push;
  logic                           pop;
  jbp_pkg::work_entry_t           entry;

  assign code_ready = (fill != 2'd2);
  assign is_flush   = (code_data.op == jbp_pkg::OP_FLUSH);
  assign n_sat      = (code_data.num_bits > MAX_N) ? MAX_N : code_data.num_bits;
  assign code_mask  = (n_sat >= jbp_pkg::NUM_BITS_W'(jbp_pkg::CODE_W)) ? '1 :
                      ((jbp_pkg::CODE_W'(1) << n_sat) - jbp_pkg::CODE_W'(1));

  // An append of zero bits has no effect and never enters the queue.
  assign push = code_valid && code_ready && (is_flush || (n_sat != '0));
  assign pop  = work_valid && work_ready;

  always_comb begin
    entry.flush    = is_flush;
    entry.num_bits = is_flush ? '0 : n_sat;
    entry.code     = is_flush ? '0 : (code_data.code_value & code_mask);
  end

  assign work_valid = (fill != 2'd0);
  assign work_data  = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        queue[wr_ptr] <= entry;
        wr_ptr        <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/jbp_back.sv @@
// ----------------------------------------------------------------------------
// JPEG bit packer engine
// Holds the bit accumulator, emits one stream byte per cycle into an output
// register while it is free, and inserts a zero byte after every 0xFF.
// ----------------------------------------------------------------------------
`default_nettype none

module jbp_back #(
  parameter int unsigned MAX_CODE_BITS = 32,
  parameter int unsigned COUNT_BITS    = 21
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  work_valid,
  output logic                       work_ready,
  input  wire jbp_pkg::work_entry_t  work_data,
  output logic                       byte_valid,
  input  wire logic                  byte_ready,
  output jbp_pkg::byte_item_t        byte_data
);

  localparam int unsigned ACC_W  = MAX_CODE_BITS + 7;
  localparam int unsigned PEND_W = $clog2(ACC_W + 1);

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  state_t                 state;
  logic [ACC_W-1:0]       acc;
  logic [PEND_W-1:0]      pending;
  logic                   stuff;
  logic [COUNT_BITS-1:0]  byte_total;

  logic                   out_free;
  logic                   emit;
  logic [PEND_W-1:0]      n_in;
  logic [PEND_W-1:0]      pending_sum;
  logic [PEND_W-1:0]      pending_rem;
  logic [7:0]             data_byte;
  logic [COUNT_BITS-1:0]  byte_total_next;
  logic [31:0]            total_wide;
  logic [ACC_W-1:0]       pad_bits;

  assign out_free    = !byte_valid || byte_ready;
  assign emit        = (state == S_EMIT) && out_free;
  assign work_ready  = (state == S_IDLE);
  assign n_in        = PEND_W'(work_data.num_bits);
  assign pending_sum = pending + n_in;
  assign pending_rem = pending - PEND_W'(8);
  assign data_byte   = 8'(acc >> pending_rem);
  assign pad_bits    = ACC_W'(8'hFF >> pending);

  assign byte_total_next = byte_total + COUNT_BITS'(1);
  assign total_wide      = 32'(byte_total_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      acc        <= '0;
      pending    <= '0;
      stuff      <= 1'b0;
      byte_total <= '0;
      byte_valid <= 1'b0;
    end else begin
      // A new byte enters the output register whenever the engine emits;
      // otherwise a taken byte leaves it empty.
      if (emit) begin
        byte_valid <= 1'b1;
      end else if (byte_ready) begin
        byte_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (work_valid) begin
            if (work_data.flush) begin
              // Pad the partial byte with ones and treat it as a full byte.
              if (pending != '0) begin
                acc     <= (acc << (PEND_W'(8) - pending)) | pad_bits;
                pending <= PEND_W'(8);
                state   <= S_EMIT;
              end
            end else begin
              acc     <= (acc << n_in) | ACC_W'(work_data.code);
              pending <= pending_sum;
              if (pending_sum >= PEND_W'(8)) begin
                state <= S_EMIT;
              end
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            byte_total            <= byte_total_next;
            byte_data.total_bytes <= total_wide[jbp_pkg::TOTAL_W-1:0];
            if (stuff) begin
              byte_data.out_byte <= jbp_pkg::STUFF_BYTE;
              byte_data.last     <= (pending < PEND_W'(8));
              stuff              <= 1'b0;
              if (pending < PEND_W'(8)) begin
                state <= S_IDLE;
              end
            end else begin
              byte_data.out_byte <= data_byte;
              byte_data.last     <= (data_byte != jbp_pkg::MARKER_BYTE) &&
                                    (pending_rem < PEND_W'(8));
              stuff              <= (data_byte == jbp_pkg::MARKER_BYTE);
              pending            <= pending_rem;
              if ((data_byte != jbp_pkg::MARKER_BYTE) && (pending_rem < PEND_W'(8))) begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/jbp_checker.sv @@
// ----------------------------------------------------------------------------
// JPEG bit packer port checker
// Watches the output channel for handshake and byte stuffing rules.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module jbp_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 byte_valid,
  input wire logic                 byte_ready,
  input wire jbp_pkg::byte_item_t  byte_data
);

  logic                        byte_xfer;
  logic                        out_stall;
  logic                        ff_xfer;
  logic                        stuff_ok;
  logic [jbp_pkg::TOTAL_W-1:0] total_seen;

  assign byte_xfer = byte_valid && byte_ready;
  assign out_stall = byte_valid && !byte_ready;
  assign ff_xfer   = byte_xfer && (byte_data.out_byte == jbp_pkg::MARKER_BYTE);
  assign stuff_ok  = (byte_data.out_byte == jbp_pkg::STUFF_BYTE) &&
                     (byte_data.total_bytes == total_seen + jbp_pkg::TOTAL_W'(1));

  // Byte total shown on the previous cycle.
  always_ff @(posedge clk) begin
    total_seen <= byte_data.total_bytes;
  end

  // A stalled output byte stays offered.
  `JBP_ASSERT(a_out_hold, clk, rst, out_stall |=> byte_valid, "stalled output dropped")

  // Nothing is offered right after reset.
  `JBP_ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) |-> !byte_valid, "output valid after reset")

  // A marker byte always has its stuffed zero after it, so it is never last.
  `JBP_ASSERT(a_ff_not_last, clk, rst, ff_xfer |-> !byte_data.last, "0xFF marked as last byte")

  // The byte after a marker is the stuffed zero, counted one higher.
  `JBP_ASSERT(a_stuff_follows, clk, rst, ff_xfer ##1 byte_valid |-> stuff_ok, "missing stuffed zero")

endmodule

bind jpeg_bit_packer_byte_stuffing_core jbp_checker u_jbp_checker (
  .clk        (clk),
  .rst        (rst),
  .byte_valid (byte_valid),
  .byte_ready (byte_ready),
  .byte_data  (byte_data)
);

`default_nettype wire

@@ tb/jpeg_bit_packer_byte_stuffing_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JPEG bit packer with byte stuffing - testbench
// Drives append and flush items into the code channel and predicts every
// scan byte, including the stuffed zero after each 0xFF, the last flag and
// the running byte total. Each byte transfer is checked in order against
// the predicted stream, under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------

module jpeg_bit_packer_byte_stuffing_core_test;

  localparam int MAX_CODE_BITS = 32;
  // Once the last predicted byte is in, at most the two queued items remain,
  // and the engine absorbs each without a byte, so this leaves ample margin.
  localparam int DRAIN_CYCLES  = 32;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 80;
  localparam int MAX_REPORTS   = 10;
  localparam int LONG_HOLD     = 400;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                code_valid = 1'b0;
  logic                code_ready;
  jbp_pkg::code_item_t code_data  = '0;
  logic                byte_valid;
  logic                byte_ready = 1'b0;
  jbp_pkg::byte_item_t byte_data;

  jpeg_bit_packer_byte_stuffing_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .code_valid(code_valid),
    .code_ready(code_ready),
    .code_data (code_data),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .byte_data (byte_data)
  );

  always #10 clk = ~clk;

  // Predicted packer state: pending code bits, their count and the byte total.
  logic [38:0]                 acc_bits      = '0;
  logic [5:0]                  pending_count = '0;
  logic [jbp_pkg::TOTAL_W-1:0] byte_count    = '0;

  // Scan bytes predicted but not yet seen on the byte channel, oldest first.
  jbp_pkg::byte_item_t expected_bytes[$];

  int       mismatch_count = 0;
  int       cycle_count    = 0;

  // Sender and receiver controls set by the test tasks.
  rx_mode_t rx_mode     = RX_ALWAYS;
  bit       tx_gaps     = 1'b0;
  int       burst_left  = 0;
  int       hold_cycles = 0;

  // The watchdog bounds the whole run, including a hung byte channel.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Queues one scan byte. A 0xFF byte is always followed by a stuffed zero,
  // and both of them advance the byte total.
  function automatic void push_byte(input logic [7:0] value);
    jbp_pkg::byte_item_t entry;
    byte_count        = byte_count + 1'b1;
    entry.out_byte    = value;
    entry.last        = 1'b0;
    entry.total_bytes = byte_count;
    expected_bytes.push_back(entry);
    if (value == jbp_pkg::MARKER_BYTE) begin
      byte_count        = byte_count + 1'b1;
      entry.out_byte    = jbp_pkg::STUFF_BYTE;
      entry.total_bytes = byte_count;
      expected_bytes.push_back(entry);
    end
  endfunction

  // Predicts the bytes that one accepted item causes. Returns 0 when the
  // block ignores the item: a zero-length append or a flush with nothing
  // pending.
  function automatic bit pack_code(input jbp_pkg::code_item_t item);
    jbp_pkg::byte_item_t tail;
    logic [63:0]         wide;
    int                  n;
    bit                  emitted;
    emitted = 1'b0;
    if (item.op == jbp_pkg::OP_APPEND) begin
      // Lengths above the widest code saturate, and bits above the length
      // are dropped.
      n = (item.num_bits > MAX_CODE_BITS) ? MAX_CODE_BITS : int'(item.num_bits);
      if (n == 0) return 1'b0;
      wide = ({25'd0, acc_bits} << n) |
             ({32'd0, item.code_value} & ((64'd1 << n) - 64'd1));
      pending_count = pending_count + 6'(n);
      while (pending_count >= 6'd8) begin
        pending_count = pending_count - 6'd8;
        push_byte(wide[pending_count +: 8]);
        emitted = 1'b1;
      end
      acc_bits = 39'(wide & ((64'd1 << pending_count) - 64'd1));
    end else begin
      if (pending_count == 6'd0) return 1'b0;
      // The partial byte is left aligned and the free low bits are ones.
      push_byte(8'((acc_bits << (6'd8 - pending_count)) | (39'hFF >> pending_count)));
      pending_count = '0;
      acc_bits      = '0;
      emitted       = 1'b1;
    end
    if (emitted) begin
      tail      = expected_bytes.pop_back();
      tail.last = 1'b1;
      expected_bytes.push_back(tail);
    end
    return 1'b1;
  endfunction

  function automatic void note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] %s", $time, msg);
  endfunction

  // Every byte transfer is compared with the oldest predicted byte.
  always @(posedge clk) begin
    jbp_pkg::byte_item_t want;
    if (!rst && byte_valid && byte_ready) begin
      if (expected_bytes.size() == 0) begin
        note_failure($sformatf("unexpected byte %02h last %0b total %0d",
                               byte_data.out_byte, byte_data.last,
                               byte_data.total_bytes));
      end else begin
        want = expected_bytes.pop_front();
        if (byte_data.out_byte !== want.out_byte || byte_data.last !== want.last ||
            byte_data.total_bytes !== want.total_bytes) begin
          note_failure($sformatf(
            "expected byte %02h last %0b total %0d, got byte %02h last %0b total %0d",
            want.out_byte, want.last, want.total_bytes,
            byte_data.out_byte, byte_data.last, byte_data.total_bytes));
        end
      end
    end
  end

  // Receiver. A long hold-off requested by a test is counted here; otherwise
  // ready follows the current mode: always, random, or a rotating pattern
  // that is reloaded now and then.
  always @(posedge clk) begin
    int          stall_left;
    int          pattern_age;
    logic [15:0] rx_pattern;
    if (stall_left == 0 && hold_cycles != 0) begin
      stall_left  = hold_cycles;
      hold_cycles = 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      byte_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: byte_ready <= 1'b1;
        RX_RANDOM: byte_ready <= ($urandom_range(0, 99) >= 35);
        default: begin
          if (pattern_age == 0) rx_pattern = 16'($urandom()) | 16'h0101;
          pattern_age = (pattern_age + 1) % 64;
          byte_ready <= rx_pattern[0];
          rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
        end
      endcase
    end
  end

  // Offers one item and waits for its transfer. With gaps enabled the
  // sender works in bursts of random length separated by idle cycles.
  task automatic send_code(input jbp_pkg::code_item_t item, output bit acted);
    int gap;
    if (tx_gaps) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        code_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 10);
      end
      burst_left--;
    end
    code_valid <= 1'b1;
    code_data  <= item;
    @(posedge clk);
    while (!code_ready) @(posedge clk);
    acted = pack_code(item);
  endtask

  task automatic put_code(input logic op, input logic [5:0] n, input logic [31:0] value);
    jbp_pkg::code_item_t item;
    bit                  acted;
    item.op         = op;
    item.num_bits   = n;
    item.code_value = value;
    send_code(item, acted);
  endtask

  // Sender pause: nothing is offered until every predicted byte has arrived,
  // then the engine gets time to finish items that produce no byte.
  task automatic wait_for_drain();
    code_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly short codes, some long ones, and a few zero or oversized lengths.
  // A share of codes with at most one zero bit makes 0xFF bytes and stuffing common.
  function automatic jbp_pkg::code_item_t random_append();
    jbp_pkg::code_item_t item;
    int                  pick;
    pick            = $urandom_range(0, 99);
    item.op         = jbp_pkg::OP_APPEND;
    if (pick < 50)      item.num_bits = 6'($urandom_range(1, 12));
    else if (pick < 80) item.num_bits = 6'($urandom_range(13, 24));
    else if (pick < 92) item.num_bits = 6'($urandom_range(25, 32));
    else if (pick < 96) item.num_bits = 6'd0;
    else                item.num_bits = 6'($urandom_range(33, 63));
    item.code_value = $urandom();
    if ($urandom_range(0, 99) < 25) begin
      item.code_value = 32'hFFFF_FFFF ^ (32'd1 << $urandom_range(0, 40));
    end
    return item;
  endfunction

  task automatic test_directed_appends();
    rx_mode = RX_RANDOM;
    tx_gaps = 1'b1;
    put_code(jbp_pkg::OP_APPEND, 6'd8, 32'h0000_00A5);
    put_code(jbp_pkg::OP_APPEND, 6'd8, 32'h0000_0000);
    put_code(jbp_pkg::OP_APPEND, 6'd8, 32'h0000_00FF);   // marker byte, stuffed
    put_code(jbp_pkg::OP_APPEND, 6'd16, 32'h0000_FFFF);
    put_code(jbp_pkg::OP_APPEND, 6'd4, 32'h0000_000A);   // two nibbles join into one byte
    put_code(jbp_pkg::OP_APPEND, 6'd4, 32'h0000_0005);
    put_code(jbp_pkg::OP_APPEND, 6'd32, 32'h1234_5678);
  endtask

  task automatic test_code_saturation();
    rx_mode = RX_PATTERN;
    put_code(jbp_pkg::OP_APPEND, 6'd0, 32'hFFFF_FFFF);   // zero length, nothing happens
    put_code(jbp_pkg::OP_APPEND, 6'd63, 32'hFFFF_FFFF);  // saturates to 32 ones, 8 bytes
    put_code(jbp_pkg::OP_APPEND, 6'd33, 32'h8000_0001);
    put_code(jbp_pkg::OP_APPEND, 6'd5, 32'hFFFF_FFF5);   // only the low five bits count
    put_code(jbp_pkg::OP_APPEND, 6'd3, 32'h0000_002A);
    put_code(jbp_pkg::OP_APPEND, 6'd32, 32'h0000_0000);
  endtask

  task automatic test_flush_padding();
    rx_mode = RX_ALWAYS;
    tx_gaps = 1'b0;
    put_code(jbp_pkg::OP_FLUSH, 6'h3F, 32'hDEAD_BEEF);   // nothing pending
    put_code(jbp_pkg::OP_APPEND, 6'd3, 32'h0000_0005);
    put_code(jbp_pkg::OP_FLUSH, 6'd40, 32'h0123_4567);   // flush fields are ignored
    put_code(jbp_pkg::OP_APPEND, 6'd1, 32'h0000_0001);
    put_code(jbp_pkg::OP_FLUSH, 6'd0, 32'h0000_0000);    // pads to 0xFF, stuffed
    put_code(jbp_pkg::OP_APPEND, 6'd7, 32'h0000_0000);
    put_code(jbp_pkg::OP_FLUSH, 6'd7, 32'hFFFF_FFFF);
    put_code(jbp_pkg::OP_FLUSH, 6'd12, 32'h0000_0FFF);   // second flush in a row
    put_code(jbp_pkg::OP_APPEND, 6'd12, 32'h0000_0ABC);
    put_code(jbp_pkg::OP_FLUSH, 6'd1, 32'h8000_0000);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // long codes, so the input queue fills and code_ready drops.
  task automatic test_output_backpressure();
    jbp_pkg::code_item_t item;
    bit                  acted;
    rx_mode     = RX_ALWAYS;
    tx_gaps     = 1'b0;
    hold_cycles = LONG_HOLD;
    repeat (24) begin
      item.op         = jbp_pkg::OP_APPEND;
      item.num_bits   = 6'd32;
      item.code_value = $urandom();
      send_code(item, acted);
    end
    wait_for_drain();
  endtask

  // Mostly well-formed scans: a run of appends closed by a flush. The rest
  // is noise with any operation and any length.
  task automatic run_random_phase(input rx_mode_t mode, input bit gaps, input int target);
    jbp_pkg::code_item_t item;
    bit                  acted;
    int                  done;
    int                  run_len;
    rx_mode = mode;
    tx_gaps = gaps;
    done    = 0;
    while (done < target) begin
      if ($urandom_range(0, 99) < 85) begin
        run_len = $urandom_range(1, 16);
        repeat (run_len) begin
          send_code(random_append(), acted);
          done += acted;
        end
        item.op         = jbp_pkg::OP_FLUSH;
        item.num_bits   = 6'($urandom());
        item.code_value = $urandom();
      end else begin
        item.op         = 1'($urandom_range(0, 1));
        item.num_bits   = 6'($urandom_range(0, 63));
        item.code_value = $urandom();
      end
      send_code(item, acted);
      done += acted;
    end
  endtask

  task automatic test_random_stream();
    run_random_phase(RX_ALWAYS, 1'b0, PHASE_ITEMS);   // no idling on either side
    wait_for_drain();
    run_random_phase(RX_RANDOM, 1'b1, PHASE_ITEMS);
    run_random_phase(RX_PATTERN, 1'b1, PHASE_ITEMS);
    wait_for_drain();
    run_random_phase(RX_RANDOM, 1'b0, PHASE_ITEMS);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed_appends();
    test_code_saturation();
    test_flush_padding();
    wait_for_drain();
    test_output_backpressure();
    test_random_stream();
    wait_for_drain();
    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
